@@ rtl/core/lbrb_pkg.sv @@
// Shared types and constants of the line-aware byte ring buffer.
`timescale 1ns / 1ps

package lbrb_pkg;

    localparam int CNT_W = 13;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_POP     = 2'd1;
    localparam logic [1:0] MODE_DISCARD = 2'd2;

    localparam logic [7:0]       NEWLINE_BYTE = 8'h0A;
    localparam logic [CNT_W-1:0] RUN_MAX      = {CNT_W{1'b1}};

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       data_byte;
        logic             end_of_write;
        logic [CNT_W-1:0] drop_count;
    } t_item;

    typedef struct packed {
        logic [7:0]       byte_out;
        logic             byte_valid;
        logic             end_of_line;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] fill_level;
        logic [CNT_W-1:0] lines_available;
    } t_result;

endpackage

@@ rtl/core/lbrb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lbrb_ctrl.sv @@
// Sequencer of the ring buffer: pointers, counters and the store accesses.
`timescale 1ns / 1ps

module lbrb_ctrl #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr,
    input  logic [lbrb_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                     i_take,
    input  lbrb_pkg::t_item          i_item,
    output logic                     o_busy,
    output logic                     o_res_load,
    output lbrb_pkg::t_result        o_res,
    output logic                     o_mem_we,
    output logic [AW-1:0]            o_mem_waddr,
    output logic [7:0]               o_mem_wdata,
    output logic [AW-1:0]            o_mem_raddr,
    input  logic [7:0]               i_mem_rdata
);

    import lbrb_pkg::*;

    localparam int CAP_RST = (DEPTH < 4096) ? DEPTH : 4096;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_DISC = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cap, n_cap;
    logic [CNT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_stored, n_stored;
    logic [CNT_W-1:0] r_lines, n_lines;
    logic [CNT_W-1:0] r_run, n_run;
    logic [CNT_W-1:0] r_walk, n_walk;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_dcount, n_dcount;

    logic [CNT_W:0]   pos;
    logic [CNT_W-1:0] drop_n;
    logic [CNT_W-1:0] run_inc;
    logic             space;

    // Advance an index by one slot, wrapping at the capacity.
    function automatic logic [CNT_W-1:0] nxt(input logic [CNT_W-1:0] idx,
                                             input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] s;
        s = {1'b0, idx} + {{CNT_W{1'b0}}, 1'b1};
        return (s >= {1'b0, cap}) ? '0 : s[CNT_W-1:0];
    endfunction

    always_comb begin
        n_state  = r_state;
        n_cap    = r_cap;
        n_head   = r_head;
        n_stored = r_stored;
        n_lines  = r_lines;
        n_run    = r_run;
        n_walk   = r_walk;
        n_rem    = r_rem;
        n_left   = r_left;
        n_dcount = r_dcount;

        o_res_load  = 1'b0;
        o_res       = '0;
        o_mem_we    = 1'b0;
        o_mem_wdata = i_item.data_byte;

        space = (r_stored < r_cap);
        pos   = {1'b0, r_head} + {1'b0, r_stored};
        if (pos >= {1'b0, r_cap}) begin
            pos = pos - {1'b0, r_cap};
        end
        o_mem_waddr = AW'(pos);
        drop_n  = (i_item.drop_count < r_stored) ? i_item.drop_count : r_stored;
        run_inc = (space && (r_run < RUN_MAX)) ? r_run + 1'b1 : r_run;

        case (r_state)
            ST_IDLE: begin
                if (i_take) begin
                    case (i_item.mode)
                        MODE_WRITE: begin
                            if (space) begin
                                o_mem_we = 1'b1;
                                n_stored = r_stored + 1'b1;
                                if (i_item.data_byte == NEWLINE_BYTE) begin
                                    n_lines = r_lines + 1'b1;
                                end
                            end
                            o_res.byte_valid = space;
                            if (i_item.end_of_write) begin
                                o_res.count = run_inc;
                                n_run       = '0;
                            end else begin
                                n_run = run_inc;
                            end
                            o_res_load = 1'b1;
                        end
                        MODE_POP: begin
                            // Head byte is being read this cycle; finish next cycle.
                            if (r_stored == '0) begin
                                o_res_load = 1'b1;
                            end else begin
                                n_state = ST_POP;
                            end
                        end
                        MODE_DISCARD: begin
                            if (drop_n == '0) begin
                                o_res_load = 1'b1;
                            end else begin
                                n_walk   = nxt(r_head, r_cap);
                                n_rem    = drop_n - 1'b1;
                                n_left   = drop_n;
                                n_dcount = drop_n;
                                n_state  = ST_DISC;
                            end
                        end
                        default: begin
                            o_res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_head   = nxt(r_head, r_cap);
                n_stored = r_stored - 1'b1;
                if ((i_mem_rdata == NEWLINE_BYTE) && (r_lines != '0)) begin
                    n_lines = r_lines - 1'b1;
                end
                o_res.byte_out    = i_mem_rdata;
                o_res.byte_valid  = 1'b1;
                o_res.end_of_line = (i_mem_rdata == NEWLINE_BYTE) || (n_stored == '0);
                o_res_load        = 1'b1;
                n_state           = ST_IDLE;
            end
            ST_DISC: begin
                // Check the byte read last cycle, issue the next read.
                if ((i_mem_rdata == NEWLINE_BYTE) && (r_lines != '0)) begin
                    n_lines = r_lines - 1'b1;
                end
                n_left = r_left - 1'b1;
                if (r_rem != '0) begin
                    n_walk = nxt(r_walk, r_cap);
                    n_rem  = r_rem - 1'b1;
                end
                if (r_left == {{(CNT_W-1){1'b0}}, 1'b1}) begin
                    n_head      = r_walk;
                    n_stored    = r_stored - r_dcount;
                    o_res.count = r_dcount;
                    o_res_load  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_res.fill_level      = n_stored;
        o_res.lines_available = n_lines;

        if (i_cfg_wr) begin
            n_cap    = (32'(i_cfg_data) > 32'(DEPTH)) ? CNT_W'(DEPTH) : i_cfg_data;
            n_head   = '0;
            n_stored = '0;
            n_lines  = '0;
            n_run    = '0;
            n_state  = ST_IDLE;
        end
    end

    assign o_mem_raddr = (r_state == ST_DISC) ? AW'(r_walk) : AW'(r_head);
    assign o_busy      = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cap    <= CNT_W'(CAP_RST);
            r_head   <= '0;
            r_stored <= '0;
            r_lines  <= '0;
            r_run    <= '0;
            r_rem    <= '0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_head   <= n_head;
            r_stored <= n_stored;
            r_lines  <= n_lines;
            r_run    <= n_run;
            r_rem    <= n_rem;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk   <= n_walk;
        r_dcount <= n_dcount;
    end

endmodule

@@ rtl/core/line_aware_byte_ring_buffer.sv @@
// Top level of the line-aware byte ring buffer: handshakes, result register, store.
// Write, empty pop and no-op load the result register on accept; a pop of a stored byte
// waits for the registered store read. One write per cycle while the result channel is not stalled.
// Discard walks the dropped bytes through the store read port, one byte per cycle.
// Reset (synchronous, active low) empties the buffer and sets capacity to min(DEPTH, 4096).
// The byte store is not cleared; only bytes that were written are ever read back.
`timescale 1ns / 1ps

module line_aware_byte_ring_buffer #(
    parameter int DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_write,
    input  logic [12:0] i_drop_count,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_byte_out,
    output logic        o_byte_valid,
    output logic        o_end_of_line,
    output logic [12:0] o_count,
    output logic [12:0] o_fill_level,
    output logic [12:0] o_lines_available,
    // capacity register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);

    import lbrb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_item         item;
    t_result       res;
    t_result       r_out;
    logic          r_out_valid;
    logic          busy;
    logic          res_load;
    logic          take;
    logic          out_take;
    logic          cfg_wr;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // Pack the payload ports into one item.
    assign item.mode         = i_mode;
    assign item.data_byte    = i_data_byte;
    assign item.end_of_write = i_end_of_write;
    assign item.drop_count   = i_drop_count;

    // Capacity writes must come only while idle (the block does not enforce it); ready when out of reset.
    assign o_cfg_ready = i_rst_n;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    // Take a new transaction only when the sequencer is idle and the result
    // register is empty or being drained this cycle; a pending result then
    // never collides with the next one. Hold the input off during reset.
    assign out_take   = r_out_valid & ~i_out_stall;
    assign o_in_stall = ~i_rst_n | busy | (r_out_valid & i_out_stall);
    assign take       = i_in_valid & ~o_in_stall;

    lbrb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_item      (item),
        .o_busy      (busy),
        .o_res_load  (res_load),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    lbrb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Result register: load a finished transaction, drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_out        = r_out.byte_out;
    assign o_byte_valid      = r_out.byte_valid;
    assign o_end_of_line     = r_out.end_of_line;
    assign o_count           = r_out.count;
    assign o_fill_level      = r_out.fill_level;
    assign o_lines_available = r_out.lines_available;

endmodule
